@@ hw/rtl/lstrh_pkg.sv @@
// Shared constants and types for the land/sea tile regrid histogram.
`timescale 1ns / 1ps
package lstrh_pkg;

  localparam int unsigned TILE_PIXELS  = 160;
  localparam int unsigned TILES_ACROSS = 36;
  localparam int unsigned HALF_TURN    = 2880;
  // tile / 36 == (tile * 911) >> 15 for every 10-bit tile number
  localparam int unsigned DIV36_MUL    = 911;
  localparam int unsigned DIV36_SHIFT  = 15;

  localparam int unsigned CS_W   = 12;  // cell_size
  localparam int unsigned NX_W   = 13;  // grid_columns
  localparam int unsigned NY_W   = 12;  // grid_rows
  localparam int unsigned DAT_W  = 13;  // config write data
  localparam int unsigned IDX_W  = 2;   // config register index
  localparam int unsigned CNT_W  = 16;  // one count
  localparam int unsigned ENT_W  = 2 * CNT_W;  // land count over sea count
  localparam int unsigned CELL_W = 26;  // flat cell number before range check
  localparam int unsigned COL_W  = 16;  // signed column arithmetic

  typedef enum logic [IDX_W-1:0] {
    REG_CELL_SIZE    = 2'd0,
    REG_GRID_COLUMNS = 2'd1,
    REG_GRID_ROWS    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_ACCUM = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

endpackage

@@ hw/rtl/lstrh_if.sv @@
// Channel interfaces: input word, result word and configuration write.
`timescale 1ns / 1ps
interface lstrh_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  tile_index;
  logic [7:0]  tile_row;
  logic [3:0]  word_column;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [15:0] cell_index;
  modport source (output valid, req_type, tile_index, tile_row, word_column, first_byte,
                  second_byte, cell_index, input ready);
  modport sink (input valid, req_type, tile_index, tile_row, word_column, first_byte,
                second_byte, cell_index, output ready);
endinterface

interface lstrh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] land_count;
  logic [15:0] sea_count;
  logic [4:0]  pixels_dropped;
  logic        status;
  modport source (output valid, land_count, sea_count, pixels_dropped, status, input ready);
  modport sink (input valid, land_count, sea_count, pixels_dropped, status, output ready);
endinterface

interface lstrh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lstrh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lstrh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/lstrh_div.sv @@
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module lstrh_div import lstrh_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [CS_W-1:0]           divisor_i,
  input  logic [1:0][CS_W-1:0]      dividend_i,
  output logic                      done_o,
  output logic [1:0][CS_W-1:0]      quo_o,
  output logic [1:0][CS_W-1:0]      rem_o
);
  localparam int unsigned STEP_W = $clog2(CS_W);

  logic [STEP_W-1:0]      cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;
  logic [CS_W-1:0]        dvs_q, dvs_d;
  logic [1:0][CS_W-1:0]   quo_q, quo_d, rem_q, rem_d;
  logic [1:0][CS_W:0]     trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], quo_q[l][CS_W-1]} - {1'b0, dvs_q};
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        if (!trial[l][CS_W]) begin
          rem_d[l] = trial[l][CS_W-1:0];
          quo_d[l] = {quo_q[l][CS_W-2:0], 1'b1};
        end else begin
          rem_d[l] = {rem_q[l][CS_W-2:0], quo_q[l][CS_W-1]};
          quo_d[l] = {quo_q[l][CS_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(CS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

@@ hw/rtl/land_sea_tile_regrid_histogram.sv @@
// Top level: land/sea tile regrid histogram around one count memory.
`timescale 1ns / 1ps
// Sequence: an accumulate word runs the divider, then S_PIX for its 16 pixels, then the
//   result state; a row off the grid skips S_PIX and a zero cell size goes straight to the
//   result state. A read passes S_RD, S_RDW and then the result state.
// Throughput: one word at a time; the 16 read-modify-write updates of an accumulate word
//   share the single read and write port of the count memory, one pixel per cycle.
// Reset: asynchronous, active low. After reset a clearing pass zeroes all MAX_CELLS
//   entries, one per cycle, before the first input word is taken; config is taken always.
module land_sea_tile_regrid_histogram import lstrh_pkg::*; #(
  parameter int unsigned MAX_CELLS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lstrh_in_if.sink    in_i,
  lstrh_out_if.source out_o,
  lstrh_cfg_if.sink   cfg_i
);
  localparam int unsigned AW = $clog2(MAX_CELLS);

  // One-hot sequencer
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_PIX   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_RDW   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [CS_W-1:0] cs_q;
  logic [NX_W-1:0] nx_q;
  logic [NY_W-1:0] ny_q;

  // Clearing pass
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // Word context
  logic [15:0]              pix_q, pix_d;
  logic [3:0]               pcnt_q, pcnt_d;
  logic signed [COL_W-1:0]  q_q, q_d;
  logic [CS_W-1:0]          r_q, r_d;
  logic [CELL_W-1:0]        rowb_q, rowb_d;
  logic                     dneg_q, dneg_d, eneg_q, eneg_d;
  logic [4:0]               drop_q, drop_d;
  logic [15:0]              cidx_q, cidx_d;
  logic [CNT_W-1:0]         res_land_q, res_land_d, res_sea_q, res_sea_d;
  logic                     res_stat_q, res_stat_d;

  // Update stage and write-back forwarding
  logic          s2_v_q, s2_v_d, s2_land_q, s2_land_d;
  logic [AW-1:0] s2_addr_q, s2_addr_d;
  logic          lw_v_q;
  logic [AW-1:0] lw_addr_q;
  logic [ENT_W-1:0] lw_data_q;

  // Result register
  logic             out_v_q, out_v_d;
  logic [CNT_W-1:0] o_land_q, o_land_d, o_sea_q, o_sea_d;
  logic [4:0]       o_drop_q, o_drop_d;
  logic             o_stat_q, o_stat_d;

  // Memory port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata, cur_ent, upd_ent;

  // Divider
  logic                 div_start, div_done;
  logic [1:0][CS_W-1:0] div_dvd, div_quo, div_rem;

  // Position of the incoming word
  logic [4:0]               t_band;
  logic [5:0]               t_mod;
  logic [12:0]              lat_pos, lon_base;
  logic signed [13:0]       d0, e0;
  logic [19:0]              band_prod;

  // Pixel binning
  logic signed [COL_W-1:0]  col_t, col_w, nx_s;
  logic                     pix_ok;
  logic [CELL_W-1:0]        cell_num;
  logic [CELL_W-1:0]        cidx_w, limit;
  logic                     in_fire, out_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Config writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= CS_W'(16);
      nx_q <= NX_W'(360);
      ny_q <= NY_W'(180);
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_CELL_SIZE:    cs_q <= cfg_i.data[CS_W-1:0];
        REG_GRID_COLUMNS: nx_q <= cfg_i.data[NX_W-1:0];
        REG_GRID_ROWS:    ny_q <= cfg_i.data[NY_W-1:0];
        default: ;
      endcase
    end
  end

  // Tile position: band by reciprocal multiply, then remainder
  assign band_prod = 20'(in_i.tile_index) * 20'(DIV36_MUL);
  assign t_band    = band_prod[DIV36_SHIFT+4:DIV36_SHIFT];
  assign t_mod     = 6'(in_i.tile_index - 10'(t_band) * 10'(TILES_ACROSS));
  assign lat_pos   = 13'(t_band) * 13'(TILE_PIXELS) + 13'(in_i.tile_row);
  assign lon_base  = 13'(t_mod) * 13'(TILE_PIXELS) + {5'd0, in_i.word_column, 4'd0};
  assign d0        = signed'({1'b0, lon_base}) - 14'sd2880;
  assign e0        = 14'sd2880 - signed'({1'b0, lat_pos});
  // Divide magnitudes; signs are restored after
  assign div_dvd[0] = d0[13] ? CS_W'(-d0) : CS_W'(d0);
  assign div_dvd[1] = e0[13] ? CS_W'(-e0) : CS_W'(e0);
  assign div_start  = in_fire && (in_i.req_type == REQ_ACCUM) && (cs_q != '0);

  lstrh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (cs_q),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Column of the current pixel: floor quotient turned into truncation, then one wrap
  assign nx_s  = signed'(COL_W'(nx_q));
  assign col_t = q_q + ((q_q < 0 && r_q != '0) ? COL_W'(1) : COL_W'(0));
  always_comb begin
    if (col_t < 0) begin
      col_w = col_t + nx_s;
    end else if (col_t >= nx_s) begin
      col_w = col_t - nx_s;
    end else begin
      col_w = col_t;
    end
  end
  assign cell_num = rowb_q + CELL_W'(unsigned'(col_w[COL_W-2:0]));
  assign pix_ok   = (col_w >= 0) && (col_w < nx_s) && (cell_num < CELL_W'(MAX_CELLS));

  // Read status from registered index
  assign cidx_w = CELL_W'(cidx_q);
  assign limit  = CELL_W'(nx_q) * CELL_W'(ny_q);

  // Update stage: forward the entry written in the previous cycle
  assign cur_ent = (lw_v_q && lw_addr_q == s2_addr_q) ? lw_data_q : mem_rdata;
  assign upd_ent = s2_land_q ? {cur_ent[ENT_W-1:CNT_W] + 1'b1, cur_ent[CNT_W-1:0]}
                             : {cur_ent[ENT_W-1:CNT_W], cur_ent[CNT_W-1:0] + 1'b1};

  assign mem_we    = (state_q == S_CLEAR) || s2_v_q;
  assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : s2_addr_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : upd_ent;
  assign mem_raddr = (state_q == S_RD) ? cidx_w[AW-1:0] : cell_num[AW-1:0];

  lstrh_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    pix_d      = pix_q;
    pcnt_d     = pcnt_q;
    q_d        = q_q;
    r_d        = r_q;
    rowb_d     = rowb_q;
    dneg_d     = dneg_q;
    eneg_d     = eneg_q;
    drop_d     = drop_q;
    cidx_d     = cidx_q;
    res_land_d = res_land_q;
    res_sea_d  = res_sea_q;
    res_stat_d = res_stat_q;
    s2_v_d     = 1'b0;
    s2_land_d  = s2_land_q;
    s2_addr_d  = s2_addr_q;
    out_v_d    = out_v_q && !out_o.ready;
    o_land_d   = o_land_q;
    o_sea_d    = o_sea_q;
    o_drop_d   = o_drop_q;
    o_stat_d   = o_stat_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(MAX_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_land_d = '0;
          res_sea_d  = '0;
          res_stat_d = 1'b0;
          drop_d     = '0;
          if (in_i.req_type == REQ_READ) begin
            cidx_d  = in_i.cell_index;
            state_d = S_RD;
          end else begin
            pix_d  = {in_i.second_byte, in_i.first_byte};
            dneg_d = d0[13];
            eneg_d = e0[13];
            pcnt_d = '0;
            if (cs_q == '0) begin
              drop_d  = 5'd16;
              state_d = S_DONE;
            end else begin
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // floor quotient and remainder of the first column offset
          if (dneg_q && div_rem[0] != '0) begin
            q_d = -signed'(COL_W'(div_quo[0])) - COL_W'(1);
            r_d = cs_q - div_rem[0];
          end else if (dneg_q) begin
            q_d = -signed'(COL_W'(div_quo[0]));
            r_d = '0;
          end else begin
            q_d = signed'(COL_W'(div_quo[0]));
            r_d = div_rem[0];
          end
          rowb_d = CELL_W'(div_quo[1]) * CELL_W'(nx_q);
          // a row south of the pole or past the grid drops the whole word
          if ((eneg_q && div_quo[1] != '0) || div_quo[1] >= ny_q) begin
            drop_d  = 5'd16;
            state_d = S_DONE;
          end else begin
            state_d = S_PIX;
          end
        end
      end
      S_PIX: begin
        if (pix_ok) begin
          s2_v_d    = 1'b1;
          s2_addr_d = cell_num[AW-1:0];
          s2_land_d = pix_q[15];
        end else begin
          drop_d = drop_q + 1'b1;
        end
        pix_d = {pix_q[14:0], 1'b0};
        // advance the column quotient by one pixel
        if ({1'b0, r_q} + 1'b1 == {1'b0, cs_q}) begin
          q_d = q_q + COL_W'(1);
          r_d = '0;
        end else begin
          r_d = r_q + 1'b1;
        end
        pcnt_d = pcnt_q + 1'b1;
        if (pcnt_q == 4'd15) begin
          state_d = S_DONE;
        end
      end
      S_RD: begin
        res_stat_d = (cidx_w >= limit) || (cidx_w >= CELL_W'(MAX_CELLS));
        state_d    = S_RDW;
      end
      S_RDW: begin
        if (!res_stat_q) begin
          res_land_d = mem_rdata[ENT_W-1:CNT_W];
          res_sea_d  = mem_rdata[CNT_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_v_q || out_o.ready) begin
          out_v_d  = 1'b1;
          o_land_d = res_land_q;
          o_sea_d  = res_sea_q;
          o_drop_d = drop_q;
          o_stat_d = res_stat_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      s2_v_q    <= 1'b0;
      lw_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      s2_v_q    <= s2_v_d;
      lw_v_q    <= s2_v_q;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    pcnt_q     <= pcnt_d;
    q_q        <= q_d;
    r_q        <= r_d;
    rowb_q     <= rowb_d;
    dneg_q     <= dneg_d;
    eneg_q     <= eneg_d;
    drop_q     <= drop_d;
    cidx_q     <= cidx_d;
    res_land_q <= res_land_d;
    res_sea_q  <= res_sea_d;
    res_stat_q <= res_stat_d;
    s2_land_q  <= s2_land_d;
    s2_addr_q  <= s2_addr_d;
    lw_addr_q  <= s2_addr_q;
    lw_data_q  <= upd_ent;
    o_land_q   <= o_land_d;
    o_sea_q    <= o_sea_d;
    o_drop_q   <= o_drop_d;
    o_stat_q   <= o_stat_d;
  end

  assign out_o.valid          = out_v_q;
  assign out_o.land_count     = o_land_q;
  assign out_o.sea_count      = o_sea_q;
  assign out_o.pixels_dropped = o_drop_q;
  assign out_o.status         = o_stat_q;

  // No word is taken while the clearing pass runs
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("input taken during clearing pass");

  // A pixel update never overlaps a clearing write
  a_upd_not_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (state_q != S_CLEAR))
    else $error("count update during clearing pass");

  // A failed read reports zero counts
  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && o_stat_q) |-> (o_land_q == '0 && o_sea_q == '0))
    else $error("failed read with nonzero counts");

  // Drop count never exceeds the word size
  a_drop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (o_drop_q <= 5'd16))
    else $error("drop count out of range");
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the land/sea tile regrid histogram.
`timescale 1ns / 1ps
module testbench;
  import lstrh_pkg::*;

  localparam int unsigned CELLS      = 65536;
  localparam int unsigned IDLE_LIMIT = 300000;  // covers the clearing pass after reset
  localparam int unsigned SETTLE     = 48;      // longer than one accumulate word

  typedef struct {
    req_e        req;
    logic [9:0]  tile_index;
    logic [7:0]  tile_row;
    logic [3:0]  word_column;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [15:0] cell_index;
  } map_word_t;

  typedef struct {
    logic [15:0] land_count;
    logic [15:0] sea_count;
    logic [4:0]  pixels_dropped;
    logic        status;
  } count_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lstrh_in_if  in_if ();
  lstrh_out_if out_if ();
  lstrh_cfg_if cfg_if ();

  land_sea_tile_regrid_histogram u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow histogram and its grid settings
  logic [15:0] land_shadow [CELLS];
  logic [15:0] sea_shadow [CELLS];
  int          cell_edge = 16;
  int          grid_cols = 360;
  int          grid_rows = 180;
  int          touched_cells[$];

  map_word_t   pending_words[$];
  count_word_t expected_counts[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hurry = 1'b0;  // no gaps on either side while set

  task automatic report(string what, int unsigned want, int unsigned got);
    errors++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Bin one word into the shadow grid, or look up one cell
  function automatic count_word_t bin_word(map_word_t w);
    count_word_t r;
    int          lat;
    int          lon;
    int          col;
    int          row;
    longint      cell_num;
    bit          land;
    r = '{default: '0};
    if (w.req == REQ_READ) begin
      if (longint'(w.cell_index) >= longint'(grid_cols) * longint'(grid_rows) ||
          int'(w.cell_index) >= CELLS) begin
        r.status = 1'b1;
      end else begin
        r.land_count = land_shadow[w.cell_index];
        r.sea_count  = sea_shadow[w.cell_index];
      end
      return r;
    end
    lat = 160 * (int'(w.tile_index) / 36) + int'(w.tile_row);
    for (int p = 0; p < 16; p++) begin
      land = (p < 8) ? w.second_byte[7-p] : w.first_byte[15-p];
      lon  = 160 * (int'(w.tile_index) % 36) + 16 * int'(w.word_column) + p;
      if (cell_edge == 0) begin
        r.pixels_dropped++;
        continue;
      end
      col = (lon - 2880) / cell_edge;
      row = (2880 - lat) / cell_edge;
      if (col < 0) col += grid_cols;
      else if (col >= grid_cols) col -= grid_cols;
      if (col < 0 || col >= grid_cols || row < 0 || row >= grid_rows) begin
        r.pixels_dropped++;
        continue;
      end
      cell_num = longint'(col) + longint'(row) * longint'(grid_cols);
      if (cell_num >= CELLS) begin
        r.pixels_dropped++;
        continue;
      end
      if (land) land_shadow[cell_num] = land_shadow[cell_num] + 16'd1;
      else sea_shadow[cell_num] = sea_shadow[cell_num] + 16'd1;
      if (touched_cells.size() < 256) touched_cells.push_back(int'(cell_num));
      else touched_cells[$urandom_range(0, 255)] = int'(cell_num);
    end
    return r;
  endfunction

  function automatic int draw_gap();
    if (hurry || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Driver: present one pending word at a time, hold it until taken
  bit        word_busy = 1'b0;
  int        send_gap = 0;
  map_word_t word_cur;

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_ACCUM;
    in_if.tile_index = '0;
    in_if.tile_row = '0;
    in_if.word_column = '0;
    in_if.first_byte = '0;
    in_if.second_byte = '0;
    in_if.cell_index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CELL_SIZE;
    cfg_if.data = '0;
    for (int i = 0; i < CELLS; i++) begin
      land_shadow[i] = '0;
      sea_shadow[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      expected_counts.push_back(bin_word(word_cur));
      word_busy = 1'b0;
      send_gap = draw_gap();
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !word_busy) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0) begin
        word_cur = pending_words.pop_front();
        word_busy = 1'b1;
        in_if.req_type    <= word_cur.req;
        in_if.tile_index  <= word_cur.tile_index;
        in_if.tile_row    <= word_cur.tile_row;
        in_if.word_column <= word_cur.word_column;
        in_if.first_byte  <= word_cur.first_byte;
        in_if.second_byte <= word_cur.second_byte;
        in_if.cell_index  <= word_cur.cell_index;
      end
    end
    in_if.valid <= word_busy;
  end

  // Monitor: stall the result side at random, check each word taken
  int          recv_gap = 0;
  count_word_t count_want;

  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      recv_gap = draw_gap();
      if (expected_counts.size() == 0) begin
        errors++;
        $display("[%0t] result word with nothing outstanding", $realtime);
      end else begin
        count_want = expected_counts.pop_front();
        if (out_if.land_count !== count_want.land_count)
          report("land_count", count_want.land_count, out_if.land_count);
        if (out_if.sea_count !== count_want.sea_count)
          report("sea_count", count_want.sea_count, out_if.sea_count);
        if (out_if.pixels_dropped !== count_want.pixels_dropped)
          report("pixels_dropped", count_want.pixels_dropped, out_if.pixels_dropped);
        if (out_if.status !== count_want.status)
          report("status", count_want.status, out_if.status);
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("** land_sea_tile_regrid_histogram: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [12:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_CELL_SIZE:    cell_edge = int'(value[11:0]);
      REG_GRID_COLUMNS: grid_cols = int'(value);
      REG_GRID_ROWS:    grid_rows = int'(value[11:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Drain: wait for all results, then let any late pixel work finish
  task automatic drain();
    wait (pending_words.size() == 0 && !word_busy && expected_counts.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(logic [12:0] cs, logic [12:0] nx, logic [12:0] ny);
    drain();
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_GRID_COLUMNS, nx);
    write_reg(REG_GRID_ROWS, ny);
  endtask

  function automatic map_word_t accum_word(int tile, int trow, int wcol, int hi, int lo);
    map_word_t w;
    w = '{req: REQ_ACCUM, tile_index: 10'(tile), tile_row: 8'(trow), word_column: 4'(wcol),
          first_byte: 8'(hi), second_byte: 8'(lo), cell_index: 16'($urandom)};
    return w;
  endfunction

  function automatic map_word_t read_word(int cell_num);
    map_word_t w;
    w = '{req: REQ_READ, tile_index: 10'($urandom), tile_row: 8'($urandom),
          word_column: 4'($urandom), first_byte: 8'($urandom), second_byte: 8'($urandom),
          cell_index: 16'(cell_num)};
    return w;
  endfunction

  // Mostly well-formed words with random content, some out-of-range noise;
  // reads favor cells that have been counted into
  function automatic map_word_t random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return accum_word($urandom_range(0, 647), $urandom_range(0, 159), $urandom_range(0, 9),
                        $urandom, $urandom);
    if (pick < 63)
      return accum_word($urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 88 && touched_cells.size() > 0)
      return read_word(touched_cells[$urandom_range(0, touched_cells.size() - 1)]);
    if (pick < 94)
      return read_word(grid_cols * grid_rows - $urandom_range(0, 1));
    return read_word($urandom);
  endfunction

  task automatic random_words(int count);
    for (int i = 0; i < count; i++) begin
      wait (pending_words.size() < 4);
      if ($urandom_range(0, 59) == 0) hurry = ~hurry;
      pending_words.push_back(random_word());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at the reset grid, reads at its edges
    pending_words.push_back(accum_word(0, 0, 0, 8'h00, 8'h00));
    pending_words.push_back(accum_word(0, 0, 0, 8'hFF, 8'hFF));
    pending_words.push_back(accum_word(647, 159, 9, 8'hA5, 8'h5A));
    pending_words.push_back(accum_word(18, 0, 0, 8'h0F, 8'hF0));
    pending_words.push_back(accum_word(35, 80, 9, 8'h81, 8'h7E));
    pending_words.push_back(accum_word(1023, 255, 15, 8'hFF, 8'h00));
    pending_words.push_back(accum_word(700, 100, 12, 8'h3C, 8'hC3));
    pending_words.push_back(read_word(0));
    pending_words.push_back(read_word(179 * 360));
    pending_words.push_back(read_word(360 * 180 - 1));
    pending_words.push_back(read_word(360 * 180));
    pending_words.push_back(read_word(16'hFFFF));
    random_words(200);

    // Finest cells: most of the globe lies beyond the store
    configure(13'd1, 13'd5760, 13'd2880);
    pending_words.push_back(accum_word(0, 0, 0, 8'hFF, 8'hFF));
    pending_words.push_back(accum_word(647, 159, 9, 8'hFF, 8'h00));
    pending_words.push_back(accum_word(324, 0, 0, 8'h55, 8'hAA));
    random_words(150);

    // Coarsest cells, then hammer the same two cells back to back
    configure(13'd2880, 13'd2, 13'd1);
    pending_words.push_back(read_word(2));
    hurry = 1'b1;
    for (int i = 0; i < 40; i++) begin
      wait (pending_words.size() < 4);
      pending_words.push_back(accum_word(0, 1, 0, 8'hFF, 8'hFF));
    end
    hurry = 1'b0;
    pending_words.push_back(read_word(0));
    pending_words.push_back(read_word(1));
    random_words(80);

    // Degenerate grid: zero size, columns and rows drop everything
    configure(13'd0, 13'd0, 13'd0);
    pending_words.push_back(accum_word(0, 0, 0, 8'hFF, 8'hFF));
    pending_words.push_back(read_word(0));
    drain();
    write_reg(REG_CELL_SIZE, 13'd16);
    random_words(30);

    // Register extremes of the bus width; bit 12 of a 12-bit register is ignored
    configure(13'h1FFF, 13'h1FFF, 13'h1FFF);
    write_reg(REG_UNUSED, 13'($urandom));
    random_words(60);

    // Ordinary grids with random registers
    configure(13'd8, 13'd720, 13'd360);
    random_words(200);
    configure(13'h1000 | 13'd32, 13'd180, 13'd90);
    random_words(150);
    configure(13'($urandom_range(1, 64)), 13'($urandom_range(1, 5760)),
              13'($urandom_range(1, 2880)));
    random_words(100);
    configure(13'd16, 13'd360, 13'd180);
    random_words(130);

    drain();
    if (errors == 0) begin
      $display("** land_sea_tile_regrid_histogram: PASSED **");
    end else begin
      $display("** land_sea_tile_regrid_histogram: FAILED **");
    end
    $finish;
  end

endmodule
